// ===== src/rgb_to_hsv_pixel_top_assert.svh =====
// Assertion macros for the pixel HSV converter checks.
`ifndef RGB_TO_HSV_PIXEL_TOP_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rgbhsv_pkg.sv =====
// Shared types and constants for the pixel HSV converter.
package rgbhsv_pkg;

  localparam int CHAN_W            = 8;
  localparam int HUE_W             = 9;
  localparam int HUE_NUM_W         = 14;
  localparam int HUE_Q_W           = 6;
  localparam int SAT_FRAC_BITS_DEF = 12;

  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_WRAP       = 9'd360;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [2:0] {
    HCASE_RED   = 3'b001,
    HCASE_GREEN = 3'b010,
    HCASE_BLUE  = 3'b100
  } hcase_t;

  typedef struct packed {
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    chan_t  vmax;
    chan_t  delta;
    hcase_t hcase;
    logic   neg;
  } pix_t;

endpackage

// ===== src/rgb_to_hsv_pixel_top.sv =====
// Pixel HSV converter: pipelined BGRA word to RGB plus hue, saturation, value.
//
// Input request: pixel_word with in_valid; taken when in_valid is high and
// in_stall is low. Blue is bits 7:0, green 15:8, red 23:16, alpha unused.
// Output request: red, green, blue, hue_degrees, saturation_q12 and
// value_level with out_valid; taken when out_valid is high and out_stall low.
// One pixel enters per cycle, back to back, while in_stall is low. The
// depth is set by the restoring divider lanes, one quotient bit per stage
// for saturation and, in the first HUE_Q_W stages, for hue in parallel,
// plus unpack, delta and final correction stages.
// Every stage holds while the stage after it is full and held, so a stall
// on the output fills empty stages first and then raises in_stall; nothing
// is dropped or repeated. Reset empties the pipeline and clears out_valid.
// The block holds no state between pixels and has no configuration.
module rgb_to_hsv_pixel_top
  import rgbhsv_pkg::*;
#(
  parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              pixel_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAN_W-1:0]        red,
  output logic [CHAN_W-1:0]        green,
  output logic [CHAN_W-1:0]        blue,
  output logic [HUE_W-1:0]         hue_degrees,
  output logic [SAT_FRAC_BITS:0]   saturation_q12,
  output logic [CHAN_W-1:0]        value_level
);

  localparam int SAT_Q_W   = SAT_FRAC_BITS + 1;
  localparam int SAT_NUM_W = CHAN_W + SAT_FRAC_BITS;
  localparam int NST       = SAT_Q_W + 3;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  assign rdy[NST] = !out_stall;
  for (genvar s = 0; s < NST; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  chan_t  in_r, in_g, in_b, in_mx, in_mn;
  hcase_t in_case;

  assign in_b = pixel_word[7:0];
  assign in_g = pixel_word[15:8];
  assign in_r = pixel_word[23:16];

  always_comb begin
    if (in_r >= in_g && in_r >= in_b) begin
      in_case = HCASE_RED;
      in_mx   = in_r;
    end else if (in_g >= in_b) begin
      in_case = HCASE_GREEN;
      in_mx   = in_g;
    end else begin
      in_case = HCASE_BLUE;
      in_mx   = in_b;
    end
    in_mn = in_r;
    if (in_g < in_mn) begin
      in_mn = in_g;
    end
    if (in_b < in_mn) begin
      in_mn = in_b;
    end
  end

  chan_t  s0_r, s0_g, s0_b, s0_mx, s0_mn;
  hcase_t s0_case;

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s0_r    <= in_r;
      s0_g    <= in_g;
      s0_b    <= in_b;
      s0_mx   <= in_mx;
      s0_mn   <= in_mn;
      s0_case <= in_case;
    end
  end

  chan_t                 s1_x, s1_y, s1_abs;
  logic                  s1_neg;
  logic [HUE_NUM_W-1:0]  s1_hnum;
  pix_t                  s1_pix;

  always_comb begin
    case (s0_case)
      HCASE_RED: begin
        s1_x = s0_g;
        s1_y = s0_b;
      end
      HCASE_GREEN: begin
        s1_x = s0_b;
        s1_y = s0_r;
      end
      HCASE_BLUE: begin
        s1_x = s0_r;
        s1_y = s0_g;
      end
      default: begin
        s1_x = s0_g;
        s1_y = s0_b;
      end
    endcase
    s1_neg  = s1_x < s1_y;
    s1_abs  = s1_neg ? s1_y - s1_x : s1_x - s1_y;
    s1_hnum = (HUE_NUM_W'(s1_abs) << 6) - (HUE_NUM_W'(s1_abs) << 2);
    s1_pix.red   = s0_r;
    s1_pix.green = s0_g;
    s1_pix.blue  = s0_b;
    s1_pix.vmax  = s0_mx;
    s1_pix.delta = s0_mx - s0_mn;
    s1_pix.hcase = s0_case;
    s1_pix.neg   = s1_neg;
  end

  pix_t                 dp   [0:SAT_Q_W];
  logic [HUE_NUM_W-1:0] hrem [0:SAT_Q_W];
  logic [HUE_Q_W-1:0]   hq   [0:SAT_Q_W];
  logic [SAT_NUM_W-1:0] srem [0:SAT_Q_W];
  logic [SAT_Q_W-1:0]   sq   [0:SAT_Q_W];

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      dp[0]   <= s1_pix;
      hrem[0] <= s1_hnum;
      hq[0]   <= '0;
      srem[0] <= {s1_pix.delta, {SAT_FRAC_BITS{1'b0}}};
      sq[0]   <= '0;
    end
  end

  for (genvar k = 0; k < SAT_Q_W; k++) begin : g_div
    localparam int SJ = SAT_Q_W - 1 - k;
    logic [SAT_NUM_W-1:0] sden;
    logic                 sge;
    logic [HUE_NUM_W-1:0] hrem_next;
    logic [HUE_Q_W-1:0]   hq_next;

    assign sden = SAT_NUM_W'(dp[k].vmax) << SJ;
    assign sge  = srem[k] >= sden;

    if (k < HUE_Q_W) begin : g_hue
      localparam int HJ = HUE_Q_W - 1 - k;
      logic [HUE_NUM_W-1:0] hden;
      logic                 hge;
      assign hden      = HUE_NUM_W'(dp[k].delta) << HJ;
      assign hge       = hrem[k] >= hden;
      assign hrem_next = hge ? hrem[k] - hden : hrem[k];
      assign hq_next   = {hq[k][HUE_Q_W-2:0], hge};
    end else begin : g_hold
      assign hrem_next = hrem[k];
      assign hq_next   = hq[k];
    end

    always_ff @(posedge clk) begin
      if (rdy[k+2] && vld[k+1]) begin
        dp[k+1]   <= dp[k];
        srem[k+1] <= sge ? srem[k] - sden : srem[k];
        sq[k+1]   <= {sq[k][SAT_Q_W-2:0], sge};
        hrem[k+1] <= hrem_next;
        hq[k+1]   <= hq_next;
      end
    end
  end

  pix_t               fp;
  logic [HUE_W-1:0]   f_q, f_ceil, hue_next;
  logic [SAT_Q_W-1:0] sat_next;

  always_comb begin
    fp     = dp[SAT_Q_W];
    f_q    = HUE_W'(hq[SAT_Q_W]);
    f_ceil = f_q + HUE_W'(hrem[SAT_Q_W] != '0);
    case (fp.hcase)
      HCASE_RED:   hue_next = fp.neg ? HUE_WRAP - f_ceil : f_q;
      HCASE_GREEN: hue_next = fp.neg ? HUE_GREEN_BASE - f_ceil : HUE_GREEN_BASE + f_q;
      HCASE_BLUE:  hue_next = fp.neg ? HUE_BLUE_BASE - f_ceil : HUE_BLUE_BASE + f_q;
      default:     hue_next = '0;
    endcase
    if (fp.delta == '0) begin
      hue_next = '0;
    end
    sat_next = (fp.vmax == '0) ? '0 : sq[SAT_Q_W];
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1] && vld[NST-2]) begin
      red            <= fp.red;
      green          <= fp.green;
      blue           <= fp.blue;
      value_level    <= fp.vmax;
      hue_degrees    <= hue_next;
      saturation_q12 <= sat_next;
    end
  end

endmodule

// ===== src/rhp_checker.sv =====
// Port-level checks for the pixel HSV converter and their binding.
`include "rgb_to_hsv_pixel_top_assert.svh"

module rhp_checker
  import rgbhsv_pkg::*;
#(
  parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [CHAN_W-1:0]      red,
  input logic [CHAN_W-1:0]      green,
  input logic [CHAN_W-1:0]      blue,
  input logic [HUE_W-1:0]       hue_degrees,
  input logic [SAT_FRAC_BITS:0] saturation_q12,
  input logic [CHAN_W-1:0]      value_level
);

  localparam logic [SAT_FRAC_BITS:0] SAT_ONE = {1'b1, {SAT_FRAC_BITS{1'b0}}};

  logic is_black;
  logic black_zero;
  logic value_ok;

  assign is_black   = value_level == '0;
  assign black_zero = saturation_q12 == '0 && hue_degrees == '0;
  assign value_ok   = value_level >= red && value_level >= green && value_level >= blue &&
                      (value_level == red || value_level == green || value_level == blue);

  `RHP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "stalled request dropped")
  `RHP_ASSERT_NOW(a_hue_range, clk, rst, out_valid, hue_degrees < HUE_WRAP, "hue out of range")
  `RHP_ASSERT_NOW(a_sat_range, clk, rst, out_valid, saturation_q12 <= SAT_ONE, "saturation above one")
  `RHP_ASSERT_NOW(a_black, clk, rst, out_valid && is_black, black_zero, "black pixel not zero")
  `RHP_ASSERT_NOW(a_value_max, clk, rst, out_valid, value_ok, "value is not the largest channel")

endmodule

bind rgb_to_hsv_pixel_top rhp_checker #(.SAT_FRAC_BITS(SAT_FRAC_BITS)) u_rhp_checker (.*);
